@@ rtl/mqrps_pkg.sv @@
package mqrps_pkg;

	localparam int NUM_QUEUES_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int QN_W = 4;
	localparam int ID_W = 16;
	localparam int RANK_W = 3;
	localparam int ENTRY_W = ID_W + RANK_W;

	localparam logic [QN_W-1:0] QCOUNT_RESET = 4'd8;
	localparam logic [RANK_W-1:0] RANK_UNKNOWN = 3'b111;

	typedef enum logic [2:0] {
		ST_ENTERED = 3'd0,
		ST_SERVED  = 3'd1,
		ST_BADQ    = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic {
		OP_ENTER = 1'b0,
		OP_SERVE = 1'b1
	} op_t;

	typedef struct packed {
		logic              bad;
		op_t               op;
		logic [QN_W-1:0]   qn;
		logic [ID_W-1:0]   id;
		logic [RANK_W-1:0] rank;
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	function automatic logic [RANK_W-1:0] clamp_rank(input logic [RANK_W-1:0] raw);
		logic [RANK_W-1:0] r;
		r = raw;
		if (raw[RANK_W-1] && raw != RANK_UNKNOWN)
			r = RANK_UNKNOWN;
		return r;
	endfunction

endpackage

@@ rtl/mqrps_ram.sv @@
module mqrps_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/mqrps_front.sv @@
module mqrps_front
	import mqrps_pkg::*;
#(
	parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [23:0]     in_data,
	input  logic            in_user,
	input  logic            cfg_we,
	input  logic [QN_W-1:0] cfg_wdata,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  logic            cmd_pop
);

	localparam logic [QN_W:0] NQ = (QN_W+1)'(NUM_QUEUES);

	logic [QN_W-1:0] queue_count_q;
	cmd_t            buf_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	logic [QN_W:0]   limit;
	logic [QN_W-1:0] qn;
	logic            push;
	cmd_t            cmd_in;

	assign qn = in_data[3:0];
	assign limit = ({1'b0, queue_count_q} < NQ) ? {1'b0, queue_count_q} : NQ;

	always_comb begin
		cmd_in.bad  = (qn == '0) || ({1'b0, qn} > limit);
		cmd_in.op   = op_t'(in_user);
		cmd_in.qn   = qn;
		cmd_in.id   = in_data[19:4];
		cmd_in.rank = clamp_rank(in_data[22:20]);
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_count_q <= QCOUNT_RESET;
		end else if (cfg_we) begin
			queue_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !cmd_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && cmd_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= cmd_in;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("command queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != 2'd0) else $error("pop from empty command queue");

endmodule

@@ rtl/mqrps_back.sv @@
module mqrps_back
	import mqrps_pkg::*;
#(
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_status,
	output logic [ID_W-1:0]   out_id,
	output logic [RANK_W-1:0] out_rank
);

	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int AW = QW + SW;
	localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);

	state_t            state_q;
	cmd_t              cmd_q;
	logic [FW-1:0]     fill_q [NUM_QUEUES];
	logic [FW-1:0]     fill_cur_q;
	logic [SW-1:0]     rd_slot_q;
	logic [SW-1:0]     best_slot_q;
	logic [ENTRY_W-1:0] best_data_q;
	status_t           res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [RANK_W-1:0] res_rank_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [RANK_W-1:0] out_rank_q;

	logic [QN_W-1:0]    qm1;
	logic [QW-1:0]      q_idx;
	logic [FW-1:0]      fill_sel;
	logic [FW-1:0]      last_f;
	logic               better;
	logic [SW-1:0]      best_slot_n;
	logic [ENTRY_W-1:0] best_data_n;
	logic               slot_last;
	logic               need_shift;
	logic               emit_go;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [SW-1:0]      rd_slot_n;

	assign qm1      = cmd_q.qn - QN_W'(1);
	assign q_idx    = qm1[QW-1:0];
	assign fill_sel = fill_q[q_idx];
	assign last_f   = fill_cur_q - FW'(1);

	assign better = (rd_slot_q == '0) ||
		($signed(ram_rdata[ENTRY_W-1 -: RANK_W]) > $signed(best_data_q[ENTRY_W-1 -: RANK_W]));
	assign best_slot_n = better ? rd_slot_q : best_slot_q;
	assign best_data_n = better ? ram_rdata : best_data_q;
	assign slot_last   = (FW'(rd_slot_q) == last_f);
	assign need_shift  = (FW'(best_slot_n) != last_f);

	assign emit_go = !out_valid_q || out_ready;
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_comb begin
		rd_slot_n = '0;
		ram_we    = 1'b0;
		ram_waddr = {q_idx, fill_sel[SW-1:0]};
		ram_wdata = {cmd_q.rank, cmd_q.id};
		unique case (state_q)
			S_EXEC: begin
				rd_slot_n = '0;
				ram_we = !cmd_q.bad && cmd_q.op == OP_ENTER && fill_sel < DEPTH_F;
			end
			S_SCAN: begin
				rd_slot_n = slot_last ? best_slot_n + SW'(1) : rd_slot_q + SW'(1);
			end
			S_SHIFT: begin
				rd_slot_n = rd_slot_q + SW'(1);
				ram_we    = 1'b1;
				ram_waddr = {q_idx, rd_slot_q - SW'(1)};
				ram_wdata = ram_rdata;
			end
			default: begin
				rd_slot_n = '0;
			end
		endcase
	end

	assign ram_raddr = {q_idx, rd_slot_n};

	mqrps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(1 << AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_QUEUES; i++)
				fill_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd_q.bad) begin
						state_q <= S_EMIT;
					end else if (cmd_q.op == OP_ENTER) begin
						if (fill_sel < DEPTH_F)
							fill_q[q_idx] <= fill_sel + FW'(1);
						state_q <= S_EMIT;
					end else if (fill_sel == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (slot_last) begin
						if (need_shift) begin
							state_q <= S_SHIFT;
						end else begin
							fill_q[q_idx] <= last_f;
							state_q <= S_EMIT;
						end
					end
				end
				S_SHIFT: begin
					if (slot_last) begin
						fill_q[q_idx] <= last_f;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE)
			cmd_q <= cmd;
		rd_slot_q <= rd_slot_n;
		if (state_q == S_EXEC) begin
			fill_cur_q   <= fill_sel;
			res_id_q     <= '0;
			res_rank_q   <= '0;
			if (cmd_q.bad)
				res_status_q <= ST_BADQ;
			else if (cmd_q.op == OP_ENTER)
				res_status_q <= (fill_sel < DEPTH_F) ? ST_ENTERED : ST_FULL;
			else if (fill_sel == '0)
				res_status_q <= ST_EMPTY;
			else
				res_status_q <= ST_SERVED;
		end
		if (state_q == S_SCAN) begin
			best_slot_q <= best_slot_n;
			best_data_q <= best_data_n;
			if (slot_last) begin
				res_id_q   <= best_data_n[ID_W-1:0];
				res_rank_q <= best_data_n[ENTRY_W-1 -: RANK_W];
			end
		end
		if (state_q == S_EMIT && emit_go) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_rank_q   <= res_rank_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_rank   = out_rank_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && !cmd_q.bad |-> fill_sel <= DEPTH_F)
		else $error("queue fill above depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHIFT) |-> FW'(rd_slot_q) < fill_cur_q)
		else $error("slot beyond queue fill");

	a_zero_unless_served: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_SERVED |-> out_id_q == '0 && out_rank_q == '0)
		else $error("nonzero payload on non-served word");

endmodule

@@ rtl/multi_queue_rank_priority_server.sv @@
// multi-queue strict-priority server with first-come tiebreak
// s_axis: one word per request. tuser[0] = op (0 enter, 1 serve); tdata holds
//   queue_number [3:0], person_id [19:4], rank [22:20], zero pad [23].
// m_axis: one word per request, in request order. tuser[2:0] = status
//   (0 entered, 1 served, 2 bad queue, 3 empty, 4 full); tdata holds
//   served_id [15:0], served_rank [18:16], zero pad [23:19].
// cfg_we / cfg_wdata write queue_count (reset 8); write only while idle.
// a front stage checks the queue number and buffers up to two requests;
// the back stage runs them one at a time against a single-port-write entry ram.
// enter or rejected requests pass through the exec and emit states of the back
// stage; a serve also scans every entry of its queue, then compacts the entries
// behind the served one, one slot per cycle through the ram port.
// reset empties every queue and needs no clearing pass; the entry ram is not
// initialized. when m_axis_tready is low the finished word is held, the back
// stage stalls after its next result, and s_axis takes two more words.
module multi_queue_rank_priority_server
	import mqrps_pkg::*;
#(
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // queue_number, person_id, rank
	input  logic [0:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // served_id, served_rank
	output logic [2:0]  m_axis_tuser,  // status
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata
);

	logic              cmd_valid;
	logic              cmd_pop;
	cmd_t              cmd;
	logic [ID_W-1:0]   out_id;
	logic [RANK_W-1:0] out_rank;

	mqrps_front #(
		.NUM_QUEUES(NUM_QUEUES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser[0]),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	mqrps_back #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(m_axis_tuser),
		.out_id    (out_id),
		.out_rank  (out_rank)
	);

	assign m_axis_tdata = {5'b0, out_rank, out_id};

endmodule

@@ dv/tb_multi_queue_rank_priority_server.sv @@
`timescale 1ns / 1ps

module tb_multi_queue_rank_priority_server;
	import mqrps_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		status_t     st;
		logic [15:0] sid;
		logic [2:0]  srank;
	} result_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  qn;
		logic [15:0] id;
		logic [2:0]  rank;
		logic        fixed;
		result_t     want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = '0;

	// mirror of the queues
	logic [15:0]       q_id [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
	logic signed [2:0] q_rank [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
	int                q_fill [NUM_QUEUES_DEF];
	logic [3:0]        q_count;

	result_t pending_results [$];
	int      mismatches = 0;
	int      cycle_count = 0;
	int      burst_left = 0;
	int      hold_reqs = 0;
	int      hold_seen = 0;
	int      hold_left = 0;
	int      rx_mode = 0;
	int      mode_left = 0;

	// expected word typed in where it is obvious, otherwise predicted
	dir_row_t dir_tab [20] = '{
		'{OP_SERVE, 4'd1,  16'h0000, 3'd0, 1'b1, '{ST_EMPTY,   16'h0000, 3'd0}},
		'{OP_ENTER, 4'd0,  16'h0001, 3'd1, 1'b1, '{ST_BADQ,    16'h0000, 3'd0}},
		'{OP_SERVE, 4'd0,  16'h0000, 3'd0, 1'b1, '{ST_BADQ,    16'h0000, 3'd0}},
		'{OP_ENTER, 4'd15, 16'hffff, 3'd3, 1'b1, '{ST_BADQ,    16'h0000, 3'd0}},
		'{OP_SERVE, 4'd9,  16'h0000, 3'd0, 1'b1, '{ST_BADQ,    16'h0000, 3'd0}},
		'{OP_ENTER, 4'd1,  16'h0000, 3'd7, 1'b1, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_ENTER, 4'd1,  16'h8001, 3'd4, 1'b1, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_ENTER, 4'd1,  16'h00ff, 3'd6, 1'b1, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_SERVE, 4'd1,  16'h0000, 3'd0, 1'b1, '{ST_SERVED,  16'h0000, 3'd7}},
		'{OP_ENTER, 4'd1,  16'hffff, 3'd3, 1'b0, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_ENTER, 4'd1,  16'h1234, 3'd3, 1'b0, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_ENTER, 4'd8,  16'h5555, 3'd0, 1'b1, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_ENTER, 4'd8,  16'haaaa, 3'd2, 1'b0, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_SERVE, 4'd1,  16'hbeef, 3'd5, 1'b1, '{ST_SERVED,  16'hffff, 3'd3}},
		'{OP_SERVE, 4'd1,  16'h0000, 3'd0, 1'b0, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_SERVE, 4'd1,  16'h0000, 3'd0, 1'b0, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_SERVE, 4'd1,  16'h0000, 3'd0, 1'b1, '{ST_SERVED,  16'h00ff, 3'd7}},
		'{OP_SERVE, 4'd1,  16'h0000, 3'd0, 1'b1, '{ST_EMPTY,   16'h0000, 3'd0}},
		'{OP_SERVE, 4'd8,  16'h0000, 3'd0, 1'b0, '{ST_ENTERED, 16'h0000, 3'd0}},
		'{OP_SERVE, 4'd8,  16'h0000, 3'd0, 1'b0, '{ST_ENTERED, 16'h0000, 3'd0}}
	};

	logic [3:0] phase_qc [8] = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd0, 4'd6, 4'd2, 4'd8};
	int         phase_len [8] = '{300, 250, 200, 250, 30, 250, 200, 300};

	multi_queue_rank_priority_server dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic result_t predict_request(input op_t op, input logic [3:0] qn,
			input logic [15:0] id, input logic [2:0] rank);
		result_t           r;
		int                lim;
		int                q;
		int                best;
		int                i;
		logic signed [2:0] rk;
		r = '{ST_ENTERED, 16'h0000, 3'd0};
		lim = (int'(q_count) < NUM_QUEUES_DEF) ? int'(q_count) : NUM_QUEUES_DEF;
		rk = rank;
		if (rank[2] && rank != RANK_UNKNOWN)
			rk = RANK_UNKNOWN;
		if (qn == 4'd0 || int'(qn) > lim) begin
			r.st = ST_BADQ;
			return r;
		end
		q = int'(qn) - 1;
		if (op == OP_ENTER) begin
			if (q_fill[q] >= QUEUE_DEPTH_DEF) begin
				r.st = ST_FULL;
			end else begin
				q_id[q][q_fill[q]] = id;
				q_rank[q][q_fill[q]] = rk;
				q_fill[q]++;
			end
			return r;
		end
		if (q_fill[q] == 0) begin
			r.st = ST_EMPTY;
			return r;
		end
		best = 0;
		for (i = 1; i < q_fill[q]; i++) begin
			if (q_rank[q][i] > q_rank[q][best])
				best = i;
		end
		r.st = ST_SERVED;
		r.sid = q_id[q][best];
		r.srank = q_rank[q][best];
		for (i = best; i + 1 < q_fill[q]; i++) begin
			q_id[q][i] = q_id[q][i + 1];
			q_rank[q][i] = q_rank[q][i + 1];
		end
		q_fill[q]--;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", field, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic push_request(input op_t op, input logic [3:0] qn, input logic [15:0] id,
			input logic [2:0] rank, input logic fixed, input result_t want);
		result_t r;
		if (burst_left == 0) begin
			if (s_axis_tvalid && $urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, rank, id, qn};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = predict_request(op, qn, id, rank);
		if (fixed)
			r = want;
		pending_results = {pending_results, r};
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_queue_count(input logic [3:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		q_count = v;
	endtask

	task automatic random_request(input int enter_pct);
		op_t         op;
		logic [3:0]  qn;
		logic [15:0] id;
		int          lim;
		op = ($urandom_range(0, 99) < enter_pct) ? OP_ENTER : OP_SERVE;
		lim = (int'(q_count) < NUM_QUEUES_DEF) ? int'(q_count) : NUM_QUEUES_DEF;
		if (lim == 0 || $urandom_range(0, 19) == 0)
			qn = 4'($urandom_range(0, 15));
		else
			qn = 4'($urandom_range(1, lim));
		case ($urandom_range(0, 9))
			0: id = 16'h0000;
			1: id = 16'hffff;
			default: id = 16'($urandom());
		endcase
		push_request(op, qn, id, 3'($urandom_range(0, 7)), 1'b0, '0);
	endtask

	// receiver: ready pattern of its own, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(10, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		result_t head;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing pending, status", int'(m_axis_tuser), -1);
			end else begin
				head = pending_results.pop_front();
				if (m_axis_tuser != head.st)
					report_mismatch("status", int'(m_axis_tuser), int'(head.st));
				if (m_axis_tdata[15:0] != head.sid)
					report_mismatch("served_id", int'(m_axis_tdata[15:0]), int'(head.sid));
				if (m_axis_tdata[18:16] != head.srank)
					report_mismatch("served_rank", int'(m_axis_tdata[18:16]),
						int'(head.srank));
			end
		end
	end

	initial begin
		int enter_pct;
		foreach (q_fill[i])
			q_fill[i] = 0;
		q_count = QCOUNT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			push_request(dir_tab[i].op, dir_tab[i].qn, dir_tab[i].id, dir_tab[i].rank,
				dir_tab[i].fixed, dir_tab[i].want);

		// fill one queue to the brim and one past it
		for (int n = 0; n < QUEUE_DEPTH_DEF + 1; n++)
			push_request(OP_ENTER, 4'd4, 16'($urandom()), 3'($urandom_range(0, 7)), 1'b0, '0);

		enter_pct = 50;
		for (int p = 0; p < 8; p++) begin
			write_queue_count(p == 7 ? 4'($urandom_range(1, 8)) : phase_qc[p]);
			for (int n = 0; n < phase_len[p]; n++) begin
				if (n % 60 == 0) begin
					case ($urandom_range(0, 2))
						0: enter_pct = 85;
						1: enter_pct = 50;
						default: enter_pct = 20;
					endcase
				end
				if (p == 1 && n == 100)
					hold_reqs++;
				if (p == 0 && n == 150)
					settle();
				random_request(enter_pct);
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
